/* src/fnms_pkg.sv */
// Shared types, constants and helpers for the fuzzy name match scorer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fnms_pkg;

  // Field and counter widths
  localparam int CHAR_W     = 16;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 6;
  localparam int SUBCNT_W   = 5;
  localparam int SCORE_W    = 6;
  localparam int LEN_W      = 5;
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = 4;
  localparam int UNIT_LIMIT = 16;
  localparam int UNIT_IDX_W = 4;
  localparam int UNITS_PER_WORD = WORD_W / CHAR_W;

  // Default query capacity
  localparam int QUERY_MAX_DEF = 16;

  // Name count stops here
  localparam logic [POS_W-1:0] NAME_COUNT_SAT = 5'd17;

  // APB register map
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam logic [2:0] REG_QUERY_LENGTH = 3'd0;
  localparam logic [2:0] REG_QUERY_LOW    = 3'd1;
  localparam logic [2:0] REG_QUERY_MID    = 3'd2;
  localparam logic [2:0] REG_QUERY_UPPER  = 3'd3;
  localparam logic [2:0] REG_QUERY_TOP    = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic step;   // take one name character
    logic load;   // form the score and clear per-name state
  } fnms_cmd_t;

  // Fold ASCII upper case to lower case
  function automatic logic [CHAR_W-1:0] fold_unit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r = c + 16'h0020;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/fuzzy_name_match_score.sv */
// Timing: a character is taken at the edge that accepts it; the score and
// m_axis_tvalid are registered together as ST_SCORE, entered after the final
// character, completes; later while an earlier score still waits for m_axis_tready.
// Throughput: one character per cycle in ST_RUN; s_axis_tready is low in ST_SCORE
// after each name. Reset clears per-name state, query registers and valid.
// Top level: ties fnms_cfg, fnms_ctrl and fnms_dp together; depends on fnms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_name_match_score #(
  parameter int QUERY_MAX = fnms_pkg::QUERY_MAX_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fnms_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fnms_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fnms_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  // Name character stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,  // [15:0] name_char
  input  wire logic                              s_axis_tlast,  // name_last
  // Score stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [7:0]                        m_axis_tdata   // [5:0] match_score, [7:6] 0
);
  import fnms_pkg::*;

  logic [LEN_W-1:0]                 query_len;
  logic [NUM_WORDS-1:0][WORD_W-1:0] query_words;
  fnms_cmd_t                        cmd;
  logic [SCORE_W-1:0]               score;

  fnms_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .query_len_o   (query_len),
    .query_words_o (query_words)
  );

  fnms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  fnms_dp #(
    .QUERY_MAX (QUERY_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .name_char_i   (s_axis_tdata[CHAR_W-1:0]),
    .query_len_i   (query_len),
    .query_words_i (query_words),
    .score_o       (score)
  );

  assign m_axis_tdata = {{(8-SCORE_W){1'b0}}, score};

endmodule

`default_nettype wire

/* src/fnms_cfg.sv */
// Configuration register file on an APB-style port: query length and
// the four query character words. Depends on fnms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnms_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fnms_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fnms_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fnms_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output logic      [fnms_pkg::LEN_W-1:0]        query_len_o,
  output logic      [fnms_pkg::NUM_WORDS-1:0][fnms_pkg::WORD_W-1:0] query_words_o
);
  import fnms_pkg::*;

  logic [LEN_W-1:0]                 len_q;
  logic [NUM_WORDS-1:0][WORD_W-1:0] words_q;
  logic [2:0]                       reg_idx;
  logic                             wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      words_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_QUERY_LENGTH: len_q      <= pwdata[LEN_W-1:0];
        REG_QUERY_LOW:    words_q[0] <= pwdata;
        REG_QUERY_MID:    words_q[1] <= pwdata;
        REG_QUERY_UPPER:  words_q[2] <= pwdata;
        REG_QUERY_TOP:    words_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_QUERY_LENGTH: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, len_q};
      REG_QUERY_LOW:    prdata = words_q[0];
      REG_QUERY_MID:    prdata = words_q[1];
      REG_QUERY_UPPER:  prdata = words_q[2];
      REG_QUERY_TOP:    prdata = words_q[3];
      default:          prdata = '0;
    endcase
  end

  assign query_len_o   = len_q;
  assign query_words_o = words_q;

endmodule

`default_nettype wire

/* src/fnms_ctrl.sv */
// Controller: accepts name characters, sequences the scoring cycle and
// owns the output valid flag. Depends on fnms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnms_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_last_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fnms_pkg::fnms_cmd_t      cmd_o
);
  import fnms_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SCORE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_RUN: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* src/fnms_dp.sv */
// Datapath: query comparators, ordered and subsequence counters,
// equality flags and the score register. Depends on fnms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnms_dp #(
  parameter int QUERY_MAX = fnms_pkg::QUERY_MAX_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fnms_pkg::fnms_cmd_t               cmd_i,
  input  wire logic [fnms_pkg::CHAR_W-1:0]       name_char_i,
  input  wire logic [fnms_pkg::LEN_W-1:0]        query_len_i,
  input  wire logic [fnms_pkg::NUM_WORDS-1:0][fnms_pkg::WORD_W-1:0] query_words_i,
  output logic      [fnms_pkg::SCORE_W-1:0]      score_o
);
  import fnms_pkg::*;

  localparam logic [POS_W-1:0] QMAX_POS = POS_W'(QUERY_MAX);

  logic [CHAR_W-1:0]     unit [UNIT_LIMIT];
  logic [UNIT_LIMIT-1:0] fold_eq;
  logic [UNIT_LIMIT-1:0] cand;
  logic [CHAR_W-1:0]     fc;
  logic [POS_W-1:0]      m;
  logic                  found;
  logic [POS_W-1:0]      pick;

  logic [POS_W-1:0]    opos_q, opos_d;
  logic                oprev_q, oprev_d;
  logic [CNT_W-1:0]    ocnt_q, ocnt_d;
  logic [POS_W-1:0]    spos_q, spos_d;
  logic [SUBCNT_W-1:0] scnt_q, scnt_d;
  logic [POS_W-1:0]    ncnt_q, ncnt_d;
  logic                exact_q, exact_d;
  logic                folded_q, folded_d;
  logic [SCORE_W-1:0]  score_q, score_d;

  logic [CHAR_W-1:0]  cur_unit;
  logic               prev_kept;
  logic [CNT_W:0]     ocnt_sum;
  logic [CNT_W-1:0]   best;

  // Clamp the query length to the capacity
  assign m  = (query_len_i > QMAX_POS) ? QMAX_POS : query_len_i;
  assign fc = fold_unit(name_char_i);

  // One comparator per query unit
  for (genvar k = 0; k < UNIT_LIMIT; k++) begin : g_lane
    assign unit[k] = query_words_i[k / UNITS_PER_WORD][(k % UNITS_PER_WORD)*CHAR_W +: CHAR_W];
    if (k < QUERY_MAX) begin : g_used
      assign fold_eq[k] = (fold_unit(unit[k]) == fc);
      assign cand[k]    = fold_eq[k] && (POS_W'(k) >= opos_q) && (POS_W'(k) < m);
    end else begin : g_unused
      assign fold_eq[k] = 1'b0;
      assign cand[k]    = 1'b0;
    end
  end

  // Pick the lowest matching unit at or past the ordered position
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = UNIT_LIMIT - 1; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        pick  = POS_W'(k);
      end
    end
  end

  assign cur_unit  = unit[ncnt_q[UNIT_IDX_W-1:0]];
  assign prev_kept = oprev_q && found && (pick == opos_q);
  assign ocnt_sum  = {1'b0, ocnt_q} + (CNT_W+1)'(1) + (CNT_W+1)'(prev_kept);
  assign best      = (ocnt_q > CNT_W'(scnt_q)) ? ocnt_q : CNT_W'(scnt_q);

  // Per-name state update
  always_comb begin
    opos_d   = opos_q;
    oprev_d  = oprev_q;
    ocnt_d   = ocnt_q;
    spos_d   = spos_q;
    scnt_d   = scnt_q;
    ncnt_d   = ncnt_q;
    exact_d  = exact_q;
    folded_d = folded_q;
    score_d  = score_q;
    if (cmd_i.load) begin
      // Form the score, then clear for the next name
      if (exact_q && ncnt_q == m) begin
        score_d = {m, 1'b1};
      end else if (folded_q && ncnt_q == m) begin
        score_d = {m, 1'b0};
      end else begin
        score_d = best;
      end
      opos_d   = '0;
      oprev_d  = 1'b0;
      ocnt_d   = '0;
      spos_d   = '0;
      scnt_d   = '0;
      ncnt_d   = '0;
      exact_d  = 1'b1;
      folded_d = 1'b1;
    end else if (cmd_i.step) begin
      // Whole-name equality
      if (ncnt_q < m) begin
        if (cur_unit != name_char_i) begin
          exact_d = 1'b0;
        end
        if (fold_unit(cur_unit) != fc) begin
          folded_d = 1'b0;
        end
      end else begin
        exact_d  = 1'b0;
        folded_d = 1'b0;
      end
      if (ncnt_q < NAME_COUNT_SAT) begin
        ncnt_d = ncnt_q + POS_W'(1);
      end
      // Ordered count with bonus for back-to-back hits
      if (opos_q < m) begin
        if (found) begin
          ocnt_d  = ocnt_sum[CNT_W] ? {CNT_W{1'b1}} : ocnt_sum[CNT_W-1:0];
          oprev_d = 1'b1;
          opos_d  = pick + POS_W'(1);
        end else begin
          opos_d  = m;
          oprev_d = 1'b0;
        end
      end
      // Plain subsequence count
      if (spos_q < m && fold_eq[spos_q[UNIT_IDX_W-1:0]]) begin
        scnt_d = scnt_q + SUBCNT_W'(1);
        spos_d = spos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opos_q   <= '0;
      oprev_q  <= 1'b0;
      ocnt_q   <= '0;
      spos_q   <= '0;
      scnt_q   <= '0;
      ncnt_q   <= '0;
      exact_q  <= 1'b1;
      folded_q <= 1'b1;
    end else begin
      opos_q   <= opos_d;
      oprev_q  <= oprev_d;
      ocnt_q   <= ocnt_d;
      spos_q   <= spos_d;
      scnt_q   <= scnt_d;
      ncnt_q   <= ncnt_d;
      exact_q  <= exact_d;
      folded_q <= folded_d;
    end
  end

  // Result register, no reset needed
  always_ff @(posedge clk_i) begin
    score_q <= score_d;
  end

  assign score_o = score_q;

endmodule

`default_nettype wire

/* test/fnms_score_checker.sv */
// Score checker for the fuzzy name match scorer: tracks query register writes,
// predicts the score of every finished name and compares it with the score stream.
// Depends on fnms_pkg for widths and register indexes.
`timescale 1ns / 1ps

module fnms_score_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port, observed only
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fnms_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fnms_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  // Name character stream, observed only
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [15:0] name_char
  input  logic                            s_axis_tlast,   // name_last
  // Score stream, observed only
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [7:0]                      m_axis_tdata,   // [5:0] match_score, [7:6] zero
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import fnms_pkg::*;

  // Per-name tracking state
  typedef struct packed {
    logic [POS_W-1:0]    ord_pos;
    logic                ord_prev;
    logic [CNT_W-1:0]    ord_cnt;
    logic [POS_W-1:0]    sub_pos;
    logic [SUBCNT_W-1:0] sub_cnt;
    logic [POS_W-1:0]    name_cnt;
    logic                exact_eq;
    logic                folded_eq;
  } name_track_t;

  localparam name_track_t FRESH_NAME = '{
    ord_pos: '0, ord_prev: 1'b0, ord_cnt: '0, sub_pos: '0, sub_cnt: '0,
    name_cnt: '0, exact_eq: 1'b1, folded_eq: 1'b1
  };

  logic [LEN_W-1:0]  cfg_length;
  logic [WORD_W-1:0] cfg_words [NUM_WORDS];
  name_track_t       track;
  logic [7:0]        expected_scores [$];
  int                failures;
  int                checked;

  // Lower ASCII capitals only
  function automatic logic [15:0] lower_ascii(input logic [15:0] u);
    if (u >= 16'h0041 && u <= 16'h005A) begin
      return u + 16'h0020;
    end
    return u;
  endfunction

  function automatic logic [15:0] query_char(input int k);
    return cfg_words[k / 4][(k % 4) * 16 +: 16];
  endfunction

  // Clamp the programmed length to the query capacity
  function automatic int active_length();
    return (int'(cfg_length) > QUERY_MAX_DEF) ? QUERY_MAX_DEF : int'(cfg_length);
  endfunction

  // Advance the tracking state by one name character
  function automatic name_track_t take_char(input name_track_t t, input logic [15:0] c,
                                            input int m);
    name_track_t n;
    logic [15:0] fc;
    int          k;
    int          sum;
    bit          found;
    n  = t;
    fc = lower_ascii(c);
    // whole-name equality
    if (int'(n.name_cnt) < m) begin
      if (query_char(n.name_cnt) != c) n.exact_eq = 1'b0;
      if (lower_ascii(query_char(n.name_cnt)) != fc) n.folded_eq = 1'b0;
    end else begin
      n.exact_eq  = 1'b0;
      n.folded_eq = 1'b0;
    end
    if (n.name_cnt < 5'd17) n.name_cnt = n.name_cnt + 1'b1;
    // forward search with a bonus for back-to-back hits
    if (int'(n.ord_pos) < m) begin
      found = 1'b0;
      k = int'(n.ord_pos);
      while (k < m && !found) begin
        if (lower_ascii(query_char(k)) == fc) found = 1'b1;
        else k++;
      end
      if (k > int'(n.ord_pos)) n.ord_prev = 1'b0;
      if (found) begin
        sum = int'(n.ord_cnt) + 1 + int'(n.ord_prev);
        n.ord_cnt  = (sum > 63) ? 6'd63 : CNT_W'(sum);
        n.ord_prev = 1'b1;
        n.ord_pos  = POS_W'(k + 1);
      end else begin
        n.ord_pos  = POS_W'(m);
        n.ord_prev = 1'b0;
      end
    end
    // plain subsequence
    if (int'(n.sub_pos) < m && lower_ascii(query_char(n.sub_pos)) == fc) begin
      n.sub_cnt = n.sub_cnt + 1'b1;
      n.sub_pos = n.sub_pos + 1'b1;
    end
    return n;
  endfunction

  // Score of a finished name, padded to the tdata byte
  function automatic logic [7:0] finished_score(input name_track_t t, input int m);
    int s;
    if (t.exact_eq && int'(t.name_cnt) == m) s = 2 * m + 1;
    else if (t.folded_eq && int'(t.name_cnt) == m) s = 2 * m;
    else s = (int'(t.ord_cnt) > int'(t.sub_cnt)) ? int'(t.ord_cnt) : int'(t.sub_cnt);
    return {2'b00, s[5:0]};
  endfunction

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  // Predict on accepted characters, compare accepted scores, follow register writes
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (!rst_ni) begin
      cfg_length = '0;
      for (int w = 0; w < NUM_WORDS; w++) cfg_words[w] = '0;
      track = FRESH_NAME;
      expected_scores.delete();
      failures = 0;
      checked  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track = take_char(track, s_axis_tdata, active_length());
        if (s_axis_tlast) begin
          expected_scores.insert(expected_scores.size(),
                                 finished_score(track, active_length()));
          track = FRESH_NAME;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_scores.size() == 0) begin
          report_failure($sformatf("score %0d with no name pending", m_axis_tdata));
        end else begin
          want = expected_scores.pop_front();
          checked++;
          if (m_axis_tdata !== want) begin
            report_failure($sformatf("score mismatch: expected %0d, got %0d",
                                     want, m_axis_tdata));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:3])
          REG_QUERY_LENGTH: cfg_length = pwdata[LEN_W-1:0];
          REG_QUERY_LOW:    cfg_words[0] = pwdata;
          REG_QUERY_MID:    cfg_words[1] = pwdata;
          REG_QUERY_UPPER:  cfg_words[2] = pwdata;
          REG_QUERY_TOP:    cfg_words[3] = pwdata;
          default: ;
        endcase
      end
    end
    fail_count_o <= failures;
    pending_o    <= expected_scores.size();
    checked_o    <= checked;
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the fuzzy name match scorer: clock, reset, APB query setup,
// name streams with random idling and stalls, and the final verdict.
// Depends on fnms_pkg, fuzzy_name_match_score and fnms_score_checker.
`timescale 1ns / 1ps

module tb_top;
  import fnms_pkg::*;

  localparam int RANDOM_ITEMS   = 700;
  localparam int PHASE_ITEMS    = 60;
  localparam int MAX_NAME_LEN   = 20;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // [15:0] name_char
  logic                  s_axis_tlast;   // name_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // [5:0] match_score, [7:6] zero

  int fail_count;
  int pending_scores;
  int scores_checked;

  bit          idling_on     = 1'b1;
  bit          stall_request = 1'b0;
  logic [15:0] query_units [UNIT_LIMIT];
  logic [15:0] name_buf [$];
  int          items_sent;
  int          names_sent;
  int          settings_count;
  int          stalled_cycles;
  int          active_len;

  fuzzy_name_match_score i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fnms_score_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending_scores),
    .checked_o     (scores_checked)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Score receiver: random backpressure, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk_i);
      end else if (idling_on) begin
        m_axis_tready <= ($urandom_range(99) >= 34);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    stalled_cycles = 0;
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("watchdog: no transfer for %0d cycles, %0d scores outstanding",
             WATCHDOG_LIMIT, pending_scores);
    $display("== FAIL ==");
    $finish;
  end

  // One APB write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [APB_DATA_W-1:0] query_word(input int w);
    return {query_units[4*w+3], query_units[4*w+2], query_units[4*w+1], query_units[4*w]};
  endfunction

  // Program length and all four query words; junk rides in the unused length bits
  task automatic load_query(input int len);
    apb_write(REG_QUERY_LENGTH, {$urandom, 27'($urandom), 5'(len)});
    apb_write(REG_QUERY_LOW,   query_word(0));
    apb_write(REG_QUERY_MID,   query_word(1));
    apb_write(REG_QUERY_UPPER, query_word(2));
    apb_write(REG_QUERY_TOP,   query_word(3));
    active_len = (len > QUERY_MAX_DEF) ? QUERY_MAX_DEF : len;
    settings_count++;
  endtask

  // Mostly a small letter set in both cases, some case-range borders, some noise
  function automatic logic [15:0] pick_unit();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return ($urandom_range(1) ? 16'h0041 : 16'h0061) + 16'($urandom_range(3));
    end else if (r < 85) begin
      case ($urandom_range(9))
        0: return 16'h0040;
        1: return 16'h0041;
        2: return 16'h005A;
        3: return 16'h005B;
        4: return 16'h0060;
        5: return 16'h0061;
        6: return 16'h007A;
        7: return 16'h007B;
        8: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] flip_case(input logic [15:0] u);
    if (u >= 16'h0041 && u <= 16'h005A) return u + 16'h0020;
    if (u >= 16'h0061 && u <= 16'h007A) return u - 16'h0020;
    return u;
  endfunction

  // Stream name_buf as one name, idling a cycle at a time at random
  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++) begin
      while (idling_on && $urandom_range(99) < 34) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'($urandom);
        s_axis_tlast  <= 1'($urandom_range(1));
      end
      @(negedge clk_i);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= name_buf[i];
      s_axis_tlast  <= (i == name_buf.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      items_sent++;
    end
    names_sent++;
  endtask

  // Drop valid and hold until every pending score is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_scores != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Build a random name around a query of m units
  task automatic build_name(input int m);
    int kind;
    int len;
    int pos;
    kind = $urandom_range(99);
    name_buf.delete();
    if (kind < 70 && m > 0) begin
      for (int i = 0; i < m; i++) name_buf.insert(name_buf.size(), query_units[i]);
      // flip case of some units
      if (kind >= 15 && kind < 30) begin
        for (int i = 0; i < m; i++) begin
          if ($urandom_range(1)) name_buf[i] = flip_case(name_buf[i]);
        end
      end
      // apply a few edits
      if (kind >= 30) begin
        repeat ($urandom_range(1, 3)) begin
          pos = $urandom_range(name_buf.size() - 1);
          case ($urandom_range(4))
            0: name_buf[pos] = pick_unit();
            1: if (name_buf.size() > 1) name_buf.delete(pos);
            2: if (name_buf.size() < MAX_NAME_LEN) name_buf.insert(pos, pick_unit());
            3: if (name_buf.size() < MAX_NAME_LEN) name_buf.insert(name_buf.size(), pick_unit());
            default: while (name_buf.size() > pos + 1) void'(name_buf.pop_back());
          endcase
        end
      end
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, MAX_NAME_LEN)
                                     : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        name_buf.insert(name_buf.size(), (kind < 85) ? pick_unit() : 16'($urandom));
      end
    end
  endtask

  // Choose a query for a random phase; phase 1 uses length 16, phase 2 length 31
  task automatic random_query(input int phase);
    int len;
    case (phase)
      1: len = 16;
      2: len = 31;
      default: begin
        case ($urandom_range(9))
          0: len = 0;
          1: len = 1;
          2: len = 16;
          3: len = $urandom_range(17, 31);
          default: len = $urandom_range(2, 15);
        endcase
      end
    endcase
    for (int i = 0; i < UNIT_LIMIT; i++) begin
      query_units[i] = (phase == 2) ? 16'hFFFF : pick_unit();
    end
    load_query(len);
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    int phase_items;
    int eff_len;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    items_sent     = 0;
    names_sent     = 0;
    settings_count = 0;
    active_len     = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty query straight after reset: every name scores zero
    name_buf = '{16'h0061};
    send_name();
    name_buf = '{16'hFFFF, 16'h0000};
    send_name();
    drain_results();

    // Mixed-case query: exact, folded, longer name, case-range borders
    query_units[0] = 16'h0048;
    query_units[1] = 16'h0065;
    query_units[2] = 16'h004C;
    query_units[3] = 16'h004C;
    query_units[4] = 16'h006F;
    for (int i = 5; i < UNIT_LIMIT; i++) query_units[i] = 16'($urandom);
    load_query(5);
    name_buf = '{16'h0048, 16'h0065, 16'h004C, 16'h004C, 16'h006F};
    send_name();
    name_buf = '{16'h0068, 16'h0065, 16'h006C, 16'h006C, 16'h006F};
    send_name();
    name_buf = '{16'h0048, 16'h0045, 16'h004C, 16'h004C, 16'h004F, 16'h004F};
    send_name();
    name_buf = '{16'h0040, 16'h005B, 16'h0060, 16'h007B};
    send_name();
    name_buf = '{16'h0041, 16'h005A, 16'h0068};
    send_name();
    drain_results();

    // Random phases, each with its own query; phases 3 and 4 run without idling
    phase = 0;
    while (items_sent < RANDOM_ITEMS + 25) begin
      phase++;
      random_query(phase);
      eff_len = active_len;
      idling_on = (phase < 3 || phase > 4);
      if (phase == 3) stall_request = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_name(eff_len);
        phase_items += name_buf.size();
        send_name();
      end
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d names (%0d characters) under %0d query settings; %0d scores checked.",
             names_sent, items_sent, settings_count, scores_checked);
    $display("Names were exact, case-flipped, edited and unrelated, with idling and a long stall.");
    if (fail_count == 0 && pending_scores == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d scores outstanding", fail_count, pending_scores);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* fuzzy_name_match_score.f */
src/fnms_pkg.sv
src/fnms_cfg.sv
src/fnms_ctrl.sv
src/fnms_dp.sv
src/fuzzy_name_match_score.sv
test/fnms_score_checker.sv
test/tb_top.sv
